// File: sv/pcapng_ipv4_flow_extractor_assert.svh
// Assertion macros used by the flow extractor checker.
// Expect i_clk and i_rst_n in the scope of every use.
`ifndef PCAPNG_IPV4_FLOW_EXTRACTOR_ASSERT_SVH
`define PCAPNG_IPV4_FLOW_EXTRACTOR_ASSERT_SVH

// Same-cycle implication.
`define PFX_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PFX_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/pfx_pkg.sv
// Shared types and constants of the pcapng IPv4 flow extractor.
// No dependencies.
`timescale 1ns / 1ps

package pfx_pkg;

    localparam int HDR_BYTES = 128;
    localparam int CI_W      = $clog2(HDR_BYTES);

    typedef logic [CI_W-1:0] t_ci;

    typedef enum logic [1:0] {
        KIND_PKT = 2'd0,
        KIND_EOF = 2'd1,
        KIND_BAD = 2'd2
    } t_kind;

    localparam logic        REQ_BYTE   = 1'b0;
    localparam logic        REQ_EOF    = 1'b1;
    localparam logic [31:0] BLK_IDB    = 32'h0000_0001;
    localparam logic [31:0] BLK_EPB    = 32'h0000_0006;
    localparam logic [15:0] LINK_ETH   = 16'h0001;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam int          ETH_HDR    = 14;

    // Content offsets of captured fields
    localparam int OFS_CAPLEN = 12;
    localparam int OFS_LINK   = 0;
    localparam int OFS_ETYPE  = 32;
    localparam int OFS_VIHL   = 34;
    localparam int OFS_TOTAL  = 36;
    localparam int OFS_PROTO  = 43;
    localparam int OFS_SRC    = 46;
    localparam int OFS_DST    = 50;

    // Offsets inside the transport header
    localparam int L4_SPORT = 0;
    localparam int L4_DPORT = 2;
    localparam int L4_ULEN  = 4;
    localparam int L4_DOFF  = 12;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        t_kind       result_kind;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [7:0]  ip_protocol;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] payload_bytes;
    } t_out;

    typedef struct packed {
        logic        is_status;
        t_kind       status;
        logic [31:0] blk_len;
        logic [31:0] cap_len;
        logic        link_eth;
        logic [15:0] ether_type;
        logic [3:0]  ihl;
        logic [15:0] ip_total;
        logic [7:0]  proto;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] udp_len;
        logic [3:0]  doff;
    } t_evt;

endpackage

// File: sv/pfx_parser.sv
// Block walker: tracks pcapng block headers, captures frame header fields on the fly
// and registers an event per packet block, short length or end marker. Uses pfx_pkg.
`timescale 1ns / 1ps

module pfx_parser import pfx_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_ev_valid,
    input  logic i_ev_ready,
    output t_evt o_ev
);

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_BODY   = 3'b010,
        PH_ERROR  = 3'b100
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_kind, n_kind;
    logic [31:0] r_len, n_len;
    logic [15:0] r_link, n_link;
    logic [31:0] r_cap, n_cap;
    logic [7:0]  r_b0, n_b0;
    logic [7:0]  r_b1, n_b1;
    logic [15:0] r_etype, n_etype;
    logic [3:0]  r_ihl, n_ihl;
    logic [15:0] r_total, n_total;
    logic [7:0]  r_proto, n_proto;
    logic [31:0] r_src, n_src;
    logic [31:0] r_dst, n_dst;
    logic [15:0] r_sport, n_sport;
    logic [15:0] r_dport, n_dport;
    logic [15:0] r_ulen, n_ulen;
    logic [3:0]  r_doff, n_doff;
    logic        r_ev_valid, n_ev_valid;
    t_evt        r_ev, n_ev;

    logic        w_accept;
    logic [7:0]  w_b;
    logic [31:0] w_ci;
    logic        w_in_content;
    logic        w_in_store;
    t_ci         w_cin;
    logic [3:0]  w_ihl;
    t_ci         w_l4;
    logic [CI_W:0] w_rel;
    logic        w_in_l4;
    logic        w_last;
    logic        w_emit;
    t_evt        w_ev;

    assign o_in_ready = !r_ev_valid || i_ev_ready;
    assign o_ev_valid = r_ev_valid;
    assign o_ev       = r_ev;

    assign w_accept     = i_in_valid && o_in_ready;
    assign w_b          = i_in_data.data_byte;
    assign w_ci         = r_pos - 32'd8;
    assign w_in_content = r_pos < (r_len - 32'd4);
    assign w_in_store   = w_in_content && (w_ci < 32'(HDR_BYTES));
    assign w_cin        = w_ci[CI_W-1:0];
    assign w_ihl        = (w_cin == t_ci'(OFS_VIHL)) ? w_b[3:0] : r_ihl;
    assign w_l4         = t_ci'(OFS_VIHL) + t_ci'({w_ihl, 2'b00});
    assign w_rel        = {1'b0, w_cin} - {1'b0, w_l4};
    assign w_in_l4      = !w_rel[CI_W];
    assign w_last       = (r_pos + 32'd1) == r_len;

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_kind     = r_kind;
        n_len      = r_len;
        n_link     = r_link;
        n_cap      = r_cap;
        n_b0       = r_b0;
        n_b1       = r_b1;
        n_etype    = r_etype;
        n_ihl      = r_ihl;
        n_total    = r_total;
        n_proto    = r_proto;
        n_src      = r_src;
        n_dst      = r_dst;
        n_sport    = r_sport;
        n_dport    = r_dport;
        n_ulen     = r_ulen;
        n_doff     = r_doff;
        n_ev_valid = r_ev_valid && !i_ev_ready;
        n_ev       = r_ev;
        w_emit     = 1'b0;
        w_ev       = '0;

        if (w_accept) begin
            if (i_in_data.req_type == REQ_EOF) begin
                n_phase = PH_HEADER;
                n_pos   = '0;
                n_kind  = '0;
                n_len   = '0;
                n_link  = LINK_ETH;
                n_cap   = '0;
                if (r_phase != PH_ERROR) begin
                    w_emit       = 1'b1;
                    w_ev.is_status = 1'b1;
                    w_ev.status  = (r_phase == PH_HEADER && r_pos == 32'd0) ? KIND_EOF
                                                                            : KIND_BAD;
                end
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        if (r_pos < 32'd4) begin
                            n_kind = {w_b, r_kind[31:8]};
                        end else begin
                            n_len = {w_b, r_len[31:8]};
                        end
                        n_pos = r_pos + 32'd1;
                        if (r_pos == 32'd7) begin
                            if (n_len < 32'd12) begin
                                n_phase        = PH_ERROR;
                                w_emit         = 1'b1;
                                w_ev.is_status = 1'b1;
                                w_ev.status    = KIND_BAD;
                            end else begin
                                n_phase = PH_BODY;
                                n_cap   = '0;
                                n_b0    = '0;
                                n_b1    = '0;
                                n_etype = '0;
                                n_ihl   = '0;
                                n_total = '0;
                                n_proto = '0;
                                n_src   = '0;
                                n_dst   = '0;
                                n_sport = '0;
                                n_dport = '0;
                                n_ulen  = '0;
                                n_doff  = '0;
                            end
                        end
                    end
                    PH_BODY: begin
                        if (w_in_content && w_ci >= 32'(OFS_CAPLEN)
                                && w_ci < 32'(OFS_CAPLEN + 4)) begin
                            n_cap = {w_b, r_cap[31:8]};
                        end
                        if (w_in_store) begin
                            case (w_cin)
                                t_ci'(OFS_LINK):      n_b0             = w_b;
                                t_ci'(OFS_LINK + 1):  n_b1             = w_b;
                                t_ci'(OFS_ETYPE):     n_etype[15:8]    = w_b;
                                t_ci'(OFS_ETYPE + 1): n_etype[7:0]     = w_b;
                                t_ci'(OFS_VIHL):      n_ihl            = w_b[3:0];
                                t_ci'(OFS_TOTAL):     n_total[15:8]    = w_b;
                                t_ci'(OFS_TOTAL + 1): n_total[7:0]     = w_b;
                                t_ci'(OFS_PROTO):     n_proto          = w_b;
                                t_ci'(OFS_SRC):       n_src[31:24]     = w_b;
                                t_ci'(OFS_SRC + 1):   n_src[23:16]     = w_b;
                                t_ci'(OFS_SRC + 2):   n_src[15:8]      = w_b;
                                t_ci'(OFS_SRC + 3):   n_src[7:0]       = w_b;
                                t_ci'(OFS_DST):       n_dst[31:24]     = w_b;
                                t_ci'(OFS_DST + 1):   n_dst[23:16]     = w_b;
                                t_ci'(OFS_DST + 2):   n_dst[15:8]      = w_b;
                                t_ci'(OFS_DST + 3):   n_dst[7:0]       = w_b;
                                default: ;
                            endcase
                            if (w_in_l4) begin
                                case (w_rel[CI_W-1:0])
                                    t_ci'(L4_SPORT):     n_sport[15:8] = w_b;
                                    t_ci'(L4_SPORT + 1): n_sport[7:0]  = w_b;
                                    t_ci'(L4_DPORT):     n_dport[15:8] = w_b;
                                    t_ci'(L4_DPORT + 1): n_dport[7:0]  = w_b;
                                    t_ci'(L4_ULEN):      n_ulen[15:8]  = w_b;
                                    t_ci'(L4_ULEN + 1):  n_ulen[7:0]   = w_b;
                                    t_ci'(L4_DOFF):      n_doff        = w_b[7:4];
                                    default: ;
                                endcase
                            end
                        end
                        n_pos = r_pos + 32'd1;
                        if (w_last) begin
                            if (r_kind == BLK_IDB && r_len >= 32'd20) begin
                                n_link = {r_b1, r_b0};
                            end
                            if (r_kind == BLK_EPB) begin
                                w_emit          = 1'b1;
                                w_ev.is_status  = 1'b0;
                                w_ev.status     = KIND_PKT;
                                w_ev.blk_len    = r_len;
                                w_ev.cap_len    = r_cap;
                                w_ev.link_eth   = (r_link == LINK_ETH);
                                w_ev.ether_type = r_etype;
                                w_ev.ihl        = r_ihl;
                                w_ev.ip_total   = r_total;
                                w_ev.proto      = r_proto;
                                w_ev.src_addr   = r_src;
                                w_ev.dst_addr   = r_dst;
                                w_ev.sport      = r_sport;
                                w_ev.dport      = r_dport;
                                w_ev.udp_len    = r_ulen;
                                w_ev.doff       = r_doff;
                            end
                            n_phase = PH_HEADER;
                            n_pos   = '0;
                            n_kind  = '0;
                            n_len   = '0;
                            n_cap   = '0;
                        end
                    end
                    PH_ERROR: ;
                    default: n_phase = PH_ERROR;
                endcase
            end
        end

        if (w_emit) begin
            n_ev_valid = 1'b1;
            n_ev       = w_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_pos      <= '0;
            r_kind     <= '0;
            r_len      <= '0;
            r_link     <= LINK_ETH;
            r_cap      <= '0;
            r_ev_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_kind     <= n_kind;
            r_len      <= n_len;
            r_link     <= n_link;
            r_cap      <= n_cap;
            r_ev_valid <= n_ev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b0    <= n_b0;
        r_b1    <= n_b1;
        r_etype <= n_etype;
        r_ihl   <= n_ihl;
        r_total <= n_total;
        r_proto <= n_proto;
        r_src   <= n_src;
        r_dst   <= n_dst;
        r_sport <= n_sport;
        r_dport <= n_dport;
        r_ulen  <= n_ulen;
        r_doff  <= n_doff;
        r_ev    <= n_ev;
    end

endmodule

// File: sv/pfx_eval.sv
// Record stage: checks a finished packet block against its captured fields,
// derives the payload length and holds the result register. Uses pfx_pkg.
`timescale 1ns / 1ps

module pfx_eval import pfx_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_ev_valid,
    output logic o_ev_ready,
    input  t_evt i_ev,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic        r_out_valid;
    t_out        r_out;

    logic [5:0]  w_ihl4;
    logic [5:0]  w_doff4;
    logic [31:0] w_l4;
    logic [6:0]  w_hdr_sum;
    logic        w_blk_ok;
    logic        w_cap_ok;
    logic        w_ip_ok;
    logic        w_tcp_ok;
    logic        w_udp_ok;
    logic [15:0] w_payload;
    logic        w_res_valid;
    t_out        w_res;

    assign w_ihl4    = {i_ev.ihl, 2'b00};
    assign w_doff4   = {i_ev.doff, 2'b00};
    assign w_l4      = 32'(ETH_HDR) + {26'd0, w_ihl4};
    assign w_hdr_sum = {1'b0, w_ihl4} + {1'b0, w_doff4};

    assign w_blk_ok = i_ev.blk_len >= 32'd32;
    assign w_cap_ok = (i_ev.cap_len != 32'd0) && (i_ev.cap_len <= i_ev.blk_len - 32'd32);
    assign w_ip_ok  = i_ev.link_eth && (i_ev.ether_type == ETYPE_IPV4)
                   && (i_ev.cap_len >= 32'd34) && (i_ev.cap_len >= w_l4);
    assign w_tcp_ok = (i_ev.proto == PROTO_TCP) && (i_ev.cap_len >= w_l4 + 32'd20)
                   && ({9'd0, w_hdr_sum} <= i_ev.ip_total);
    assign w_udp_ok = (i_ev.proto == PROTO_UDP) && (i_ev.cap_len >= w_l4 + 32'd8)
                   && (i_ev.udp_len >= 16'd8);

    always_comb begin
        w_payload = '0;
        if (w_tcp_ok) begin
            w_payload = i_ev.ip_total - {9'd0, w_hdr_sum};
        end else if (w_udp_ok) begin
            w_payload = i_ev.udp_len - 16'd8;
        end

        w_res = '0;
        if (i_ev.is_status) begin
            w_res.result_kind = i_ev.status;
            w_res_valid       = 1'b1;
        end else begin
            w_res.result_kind   = KIND_PKT;
            w_res.src_addr      = i_ev.src_addr;
            w_res.dst_addr      = i_ev.dst_addr;
            w_res.ip_protocol   = i_ev.proto;
            w_res.sport         = i_ev.sport;
            w_res.dport         = i_ev.dport;
            w_res.payload_bytes = w_payload;
            w_res_valid = w_blk_ok && w_cap_ok && w_ip_ok && (w_payload != 16'd0);
        end
    end

    assign o_ev_ready  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ev_ready) begin
            r_out_valid <= i_ev_valid && w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ev_ready && i_ev_valid && w_res_valid) begin
            r_out <= w_res;
        end
    end

endmodule

// File: sv/pcapng_ipv4_flow_extractor.sv
// Top level of the pcapng IPv4 flow extractor.
// Instantiates pfx_parser and pfx_eval; uses pfx_pkg.
`timescale 1ns / 1ps

// Input channel (i_in_valid / o_in_ready / i_in_data): one capture file byte per
// transfer with req_type 0, and one transfer with req_type 1 at the end of each file.
// Output channel (o_out_valid / i_out_ready / o_out_data): a packet record after the
// last trailer byte of each qualifying enhanced packet block, a clean end-of-file
// status, or a malformed status after a short block length or a mid-block end.
// Throughput: one input transfer per cycle unless both result registers are full,
// set by the byte-wide parser. A result is held first in the parser event register
// and then in the output register.
// Reset: parser returns to the start of a file with link type Ethernet; both
// result registers empty.
// Receiver stall: the output register holds its record; the event register
// still takes one more result, and bytes that cause no result keep flowing.
// The input is held off only when both registers are full.

module pcapng_ipv4_flow_extractor import pfx_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic w_ev_valid;
    logic w_ev_ready;
    t_evt w_ev;

    pfx_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_ev_valid (w_ev_valid),
        .i_ev_ready (w_ev_ready),
        .o_ev       (w_ev)
    );

    pfx_eval u_eval (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ev_valid  (w_ev_valid),
        .o_ev_ready  (w_ev_ready),
        .i_ev        (w_ev),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// File: sv/pfx_chk.sv
// Port-level checker for the flow extractor, bound to the top level.
// Uses pfx_pkg and pcapng_ipv4_flow_extractor_assert.svh.
`timescale 1ns / 1ps
`include "pcapng_ipv4_flow_extractor_assert.svh"

module pfx_chk import pfx_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    logic w_stall;
    logic w_status;
    logic w_pkt;
    logic w_fields_zero;
    logic w_pkt_ok;
    logic w_room;

    assign w_stall       = o_out_valid && !i_out_ready;
    assign w_status      = o_out_valid && (o_out_data.result_kind != KIND_PKT);
    assign w_pkt         = o_out_valid && (o_out_data.result_kind == KIND_PKT);
    assign w_fields_zero = ({o_out_data.src_addr, o_out_data.dst_addr, o_out_data.ip_protocol,
                             o_out_data.sport, o_out_data.dport,
                             o_out_data.payload_bytes} == '0);
    assign w_pkt_ok      = (o_out_data.payload_bytes != 16'd0)
                        && (o_out_data.ip_protocol == PROTO_TCP
                            || o_out_data.ip_protocol == PROTO_UDP);
    assign w_room        = !o_out_valid || i_out_ready;

    `PFX_ASSERT_NXT(a_out_hold, w_stall, o_out_valid && $stable(o_out_data), "result changed in stall")

    `PFX_ASSERT_IMP(a_status_clear, w_status, w_fields_zero, "status result carries packet fields")

    `PFX_ASSERT_IMP(a_pkt_fields, w_pkt, w_pkt_ok, "bad packet record")

    `PFX_ASSERT_IMP(a_in_ready, w_room, o_in_ready, "input held off with room for a result")

endmodule

bind pcapng_ipv4_flow_extractor pfx_chk u_chk (.*);
